// ===== hdl/xcfr_pkg.sv =====
package xcfr_pkg;

  // Field widths fixed by the frame format
  localparam int BYTE_W    = 8;
  localparam int PLEN_W    = 5;
  localparam int STATUS_W  = 2;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Default payload store depth
  localparam int PAYLOAD_MAX_DEF = 16;

  // Body bytes ahead of the payload: command and length
  localparam int BODY_OFS = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'h03;
  localparam logic [PLEN_W-1:0] PAYLOAD_LEN_RST = 5'd8;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_END = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_BAD_SUM = 2'd3
  } status_t;

  // Receiver phases
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_BODY   = 2'd1,
    PH_END    = 2'd2,
    PH_REPLAY = 2'd3
  } phase_t;

endpackage

// ===== hdl/xor_checksum_frame_receiver_top.sv =====
// Channel   Direction  Beat contents
// in_*      in         rx_byte
// out_*     out        status, command, data_byte, byte_index, last
// cfg_*     in         write: index, data (start byte, end byte, payload length)
//
// Every body byte is taken as soon as it is valid; bytes are never stalled while hunting or
// collecting the body. The end byte waits until the output register is empty.
// A good frame replays its payload from the store (read a byte, then load the output
// register; no new read until the last is loaded); input stalls during the replay.
// Reset (rst_n low at a clock edge) restores register defaults and hunting.
// A stalled result holds in the output register until taken.
module xor_checksum_frame_receiver_top
  import xcfr_pkg::*;
#(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [BYTE_W-1:0]    out_command,
  output logic [BYTE_W-1:0]    out_data_byte,
  output logic [IDX_W-1:0]     out_byte_index,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int LW = $clog2(PAYLOAD_MAX + 1);

  logic [BYTE_W-1:0] start_r;
  logic [BYTE_W-1:0] end_r;
  logic [PLEN_W-1:0] plen_r;
  logic [LW-1:0]     eff_len;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_BYTE_RST;
      end_r   <= END_BYTE_RST;
      plen_r  <= PAYLOAD_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE:  start_r <= cfg_wdata;
        REG_END_BYTE:    end_r   <= cfg_wdata;
        REG_PAYLOAD_LEN: plen_r  <= cfg_wdata[PLEN_W-1:0];
        default:         ;
      endcase
    end
  end

  // Clamp payload length to 1..PAYLOAD_MAX
  always_comb begin
    if (plen_r == '0) begin
      eff_len = LW'(1);
    end else if (int'(plen_r) > PAYLOAD_MAX) begin
      eff_len = LW'(PAYLOAD_MAX);
    end else begin
      eff_len = LW'(plen_r);
    end
  end

  xcfr_ctrl #(
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .AW          (AW),
    .LW          (LW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .start_byte     (start_r),
    .end_byte       (end_r),
    .eff_len        (eff_len),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_command    (out_command),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

  xcfr_payload_mem #(
    .DEPTH (PAYLOAD_MAX),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== hdl/xcfr_payload_mem.sv =====
module xcfr_payload_mem
  import xcfr_pkg::*;
#(
  parameter int DEPTH = PAYLOAD_MAX_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Write one payload byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/xcfr_ctrl.sv =====
module xcfr_ctrl
  import xcfr_pkg::*;
#(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  parameter int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1,
  parameter int LW = $clog2(PAYLOAD_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  // received bytes
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   in_rx_byte,
  // configuration
  input  logic [BYTE_W-1:0]   start_byte,
  input  logic [BYTE_W-1:0]   end_byte,
  input  logic [LW-1:0]       eff_len,
  // payload store
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [BYTE_W-1:0]   wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [BYTE_W-1:0]   rd_data,
  // results
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [BYTE_W-1:0]   out_command,
  output logic [BYTE_W-1:0]   out_data_byte,
  output logic [IDX_W-1:0]    out_byte_index,
  output logic                out_last
);

  localparam int CW = $clog2(PAYLOAD_MAX + BODY_OFS + 1);

  phase_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r;
  logic [BYTE_W-1:0]   cmd_r;
  logic [BYTE_W-1:0]   len_r;
  logic [BYTE_W-1:0]   xor_r;
  logic [BYTE_W-1:0]   chk_r;
  logic [AW-1:0]       k_r;
  logic                pend_r;
  logic [AW-1:0]       pend_idx_r;
  logic                pend_last_r;

  logic                ov_r;
  status_t             o_status_r;
  logic [BYTE_W-1:0]   o_cmd_r;
  logic [BYTE_W-1:0]   o_data_r;
  logic [IDX_W-1:0]    o_idx_r;
  logic                o_last_r;

  logic                in_acc;
  logic                out_free;
  logic                issue;
  logic                ck_pos;
  logic [CW-1:0]       ck_lim;
  logic                k_last;
  status_t             judge;
  logic                err_load;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;
  assign ck_lim   = CW'(eff_len) + CW'(BODY_OFS);
  assign ck_pos   = (cnt_r >= ck_lim);
  assign k_last   = ((LW'(k_r) + LW'(1)) == eff_len);

  // Judge the frame: end byte, then length field, then checksum
  always_comb begin
    if (in_rx_byte != end_byte) begin
      judge = ST_BAD_END;
    end else if (len_r != BYTE_W'(eff_len)) begin
      judge = ST_BAD_LEN;
    end else if (xor_r != chk_r) begin
      judge = ST_BAD_SUM;
    end else begin
      judge = ST_OK;
    end
  end

  // Next phase
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PH_HUNT: begin
        if (in_acc && (in_rx_byte == start_byte)) state_nxt = PH_BODY;
      end
      PH_BODY: begin
        if (in_acc && ck_pos) state_nxt = PH_END;
      end
      PH_END: begin
        if (in_acc) state_nxt = (judge == ST_OK) ? PH_REPLAY : PH_HUNT;
      end
      PH_REPLAY: begin
        if (issue && k_last) state_nxt = PH_HUNT;
      end
      default: state_nxt = PH_HUNT;
    endcase
  end

  // Phase outputs: input stall, store access
  always_comb begin
    in_stall = 1'b0;
    issue    = 1'b0;
    wr_en    = 1'b0;
    case (state_r)
      PH_HUNT: begin
        in_stall = 1'b0;
      end
      PH_BODY: begin
        wr_en = in_acc && !ck_pos && (cnt_r >= CW'(BODY_OFS));
      end
      PH_END: begin
        in_stall = ov_r || pend_r;
      end
      PH_REPLAY: begin
        in_stall = 1'b1;
        issue    = !pend_r && out_free;
      end
      default: in_stall = 1'b0;
    endcase
  end

  assign wr_addr  = AW'(cnt_r - CW'(BODY_OFS));
  assign wr_data  = in_rx_byte;
  assign rd_en    = issue;
  assign rd_addr  = k_r;
  assign err_load = in_acc && (state_r == PH_END) && (judge != ST_OK);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_HUNT;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      if (err_load || pend_r) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Frame body capture, running checksum and replay index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cmd_r <= '0;
      len_r <= '0;
      xor_r <= '0;
      chk_r <= '0;
      k_r   <= '0;
    end else begin
      case (state_r)
        PH_HUNT: begin
          if (in_acc && (in_rx_byte == start_byte)) begin
            cnt_r <= '0;
            xor_r <= '0;
          end
        end
        PH_BODY: begin
          if (in_acc) begin
            if (ck_pos) begin
              chk_r <= in_rx_byte;
            end else begin
              if (cnt_r == CW'(0)) cmd_r <= in_rx_byte;
              if (cnt_r == CW'(1)) len_r <= in_rx_byte;
              xor_r <= xor_r ^ in_rx_byte;
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        PH_END: begin
          k_r <= '0;
        end
        PH_REPLAY: begin
          if (issue) k_r <= k_r + AW'(1);
        end
        default: k_r <= '0;
      endcase
    end
  end

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_r  <= k_r;
      pend_last_r <= k_last;
    end
  end

  // Output register: error result or replayed payload byte
  always_ff @(posedge clk) begin
    if (err_load) begin
      o_status_r <= judge;
      o_cmd_r    <= cmd_r;
      o_data_r   <= '0;
      o_idx_r    <= '0;
      o_last_r   <= 1'b1;
    end else if (pend_r) begin
      o_status_r <= ST_OK;
      o_cmd_r    <= cmd_r;
      o_data_r   <= rd_data;
      o_idx_r    <= IDX_W'(pend_idx_r);
      o_last_r   <= pend_last_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = o_status_r;
  assign out_command    = o_cmd_r;
  assign out_data_byte  = o_data_r;
  assign out_byte_index = o_idx_r;
  assign out_last       = o_last_r;

endmodule
